>>> sv/srr_pkg.sv
// srr_pkg: shared types and constants for the selective-repeat receiver core
// holds controller/datapath command and status structs, field widths and result codes
// no dependencies
package srr_pkg;

  localparam int SEQ_W = 32;
  localparam int WIN_W = 6;
  localparam int CNT_W = $clog2(SEQ_W);

  localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic take_cfg;
    logic mod_step;
    logic check;
    logic ack_load;
    logic drain_step;
    logic deliv_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic mod_last;
    logic ack_last;
    logic run_last;
    logic out_free;
  } status_t;

endpackage

>>> sv/srr_ram.sv
// srr_ram: generic single write port, single read port ram with registered read
// no dependencies
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/srr_ctrl.sv
// srr_ctrl: sequencing state machine of the selective-repeat receiver
// depends on srr_pkg for the command and status structs
module srr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             cfg_valid,
  input  srr_pkg::status_t st,
  output srr_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             cfg_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECALC,
    S_CHECK,
    S_ACK,
    S_DRAIN,
    S_DELIV
  } state_t;

  state_t state_r, state_nxt;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.take_cfg = 1'b1;
          state_nxt    = S_RECALC;
        end else if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_RECALC: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (st.drop) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.ack_load = 1'b1;
          state_nxt    = st.ack_last ? S_IDLE : S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain_step = 1'b1;
        state_nxt      = S_DELIV;
      end
      S_DELIV: begin
        if (st.out_free) begin
          cmd.deliv_load = 1'b1;
          state_nxt      = st.run_last ? S_IDLE : S_DRAIN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_dual_take: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_item && cmd.take_cfg))
    else $error("item and window write taken in the same cycle");
  a_check_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_item |=> cmd.check)
    else $error("range check did not follow an accepted beat");
  a_drain_then_deliv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |=> !cmd.drain_step && !cmd.ack_load)
    else $error("drain step not followed by a delivery cycle");
`endif

endmodule

>>> sv/srr_dpath.sv
// srr_dpath: window registers, receive marks, payload store, modulo unit and output register
// depends on srr_pkg and srr_ram
module srr_dpath #(
  parameter int MAX_WINDOW   = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srr_pkg::cmd_t                   cmd,
  output srr_pkg::status_t                st,
  input  logic [srr_pkg::SEQ_W-1:0]       in_seq_number,
  input  logic [PAYLOAD_BITS-1:0]         in_data_word,
  input  logic                            in_checksum_ok,
  input  logic [srr_pkg::WIN_W-1:0]       cfg_window_size,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            out_result_kind,
  output logic [srr_pkg::SEQ_W-1:0]       out_ack_number,
  output logic [PAYLOAD_BITS-1:0]         out_delivered_word,
  output logic                            out_last_result
);

  localparam int SEQ_W  = srr_pkg::SEQ_W;
  localparam int WIN_W  = srr_pkg::WIN_W;
  localparam int CNT_W  = srr_pkg::CNT_W;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [WIN_W-1:0] MAX_WIN_L = WIN_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(SEQ_W - 1);

  // window and control state
  logic [WIN_W-1:0]      window_r;
  logic [SEQ_W-1:0]      base_r;
  logic [SLOT_W-1:0]     bslot_r;
  logic [MAX_WINDOW-1:0] marks_r;
  logic [WIN_W-1:0]      count_r;
  logic                  run_last_r;

  // current item
  logic [SEQ_W-1:0]        seq_r;
  logic [PAYLOAD_BITS-1:0] word_r;
  logic                    ok_r;
  logic                    drop_r;
  logic                    new_r;
  logic [SLOT_W-1:0]       slot_r;

  // modulo unit
  logic [SEQ_W-1:0] mod_q_r;
  logic [WIN_W-1:0] mod_rem_r;
  logic [CNT_W-1:0] mod_cnt_r;

  // output register
  logic                    out_valid_r;
  logic                    out_kind_r;
  logic [SEQ_W-1:0]        out_ack_r;
  logic [PAYLOAD_BITS-1:0] out_word_r;
  logic                    out_last_r;

  logic [PAYLOAD_BITS-1:0] ram_rd_data;
  logic                    ram_wr_en;

  // effective window, clamped to 1..MAX_WINDOW
  logic [WIN_W-1:0] w_eff;
  always_comb begin
    if (window_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_r > MAX_WIN_L) begin
      w_eff = MAX_WIN_L;
    end else begin
      w_eff = window_r;
    end
  end

  // range check and slot of a new packet
  logic [SEQ_W-1:0] lo;
  logic [SEQ_W:0]   hi;
  logic [SEQ_W-1:0] diff;
  logic [WIN_W:0]   slot_sum;
  logic [WIN_W:0]   slot_fix;
  logic             drop_nxt;

  always_comb begin
    lo       = (base_r >= SEQ_W'(w_eff)) ? (base_r - SEQ_W'(w_eff)) : '0;
    hi       = {1'b0, base_r} + (SEQ_W+1)'(w_eff);
    drop_nxt = !ok_r || (seq_r < lo) || ({1'b0, seq_r} >= hi);
    diff     = seq_r - base_r;
    slot_sum = (WIN_W+1)'(bslot_r) + {1'b0, diff[WIN_W-1:0]};
    slot_fix = (slot_sum >= {1'b0, w_eff}) ? (slot_sum - {1'b0, w_eff}) : slot_sum;
  end

  // restoring remainder step, one bit of base per cycle
  logic [WIN_W:0]   mod_shift;
  logic [WIN_W-1:0] mod_rem_nxt;
  always_comb begin
    mod_shift   = {mod_rem_r, mod_q_r[SEQ_W-1]};
    mod_rem_nxt = (mod_shift >= {1'b0, w_eff}) ? WIN_W'(mod_shift - {1'b0, w_eff})
                                               : WIN_W'(mod_shift);
  end

  // next base slot, base wraps to zero at the top of the sequence range
  logic [SLOT_W-1:0] bslot_nxt;
  logic [WIN_W-1:0]  count_inc;
  always_comb begin
    if (base_r == '1 || WIN_W'(bslot_r) == (w_eff - WIN_W'(1))) begin
      bslot_nxt = '0;
    end else begin
      bslot_nxt = bslot_r + SLOT_W'(1);
    end
    count_inc = count_r + WIN_W'(1);
  end

  logic dup;
  assign dup       = marks_r[slot_r];
  assign ram_wr_en = cmd.ack_load && new_r && !dup;

  assign st.drop     = drop_r;
  assign st.mod_last = (mod_cnt_r == MOD_LAST);
  assign st.ack_last = !new_r || dup || !(marks_r[bslot_r] || (slot_r == bslot_r));
  assign st.run_last = run_last_r;
  assign st.out_free = !out_valid_r || !out_stall;

  srr_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(slot_r),
    .wr_data(word_r),
    .rd_en  (cmd.drain_step),
    .rd_addr(bslot_r),
    .rd_data(ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= srr_pkg::WIN_RESET;
      base_r      <= '0;
      bslot_r     <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take_cfg) begin
        window_r <= cfg_window_size;
      end
      if (cmd.mod_step && st.mod_last) begin
        bslot_r <= SLOT_W'(mod_rem_nxt);
      end
      if (ram_wr_en) begin
        marks_r[slot_r] <= 1'b1;
      end
      if (cmd.drain_step) begin
        marks_r[bslot_r] <= 1'b0;
        base_r           <= base_r + SEQ_W'(1);
        bslot_r          <= bslot_nxt;
      end
      if (cmd.ack_load || cmd.deliv_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, modulo and output payload
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      seq_r  <= in_seq_number;
      word_r <= in_data_word;
      ok_r   <= in_checksum_ok;
    end
    if (cmd.check) begin
      drop_r <= drop_nxt;
      new_r  <= (seq_r >= base_r);
      slot_r <= SLOT_W'(slot_fix);
    end
    if (cmd.take_cfg) begin
      mod_q_r   <= base_r;
      mod_rem_r <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      mod_q_r   <= {mod_q_r[SEQ_W-2:0], 1'b0};
      mod_rem_r <= mod_rem_nxt;
      mod_cnt_r <= mod_cnt_r + CNT_W'(1);
    end
    if (cmd.ack_load) begin
      count_r <= '0;
    end else if (cmd.drain_step) begin
      count_r    <= count_inc;
      // when base wraps onto the slot being cleared, that slot reads as empty
      run_last_r <= !((count_inc < w_eff) && (bslot_nxt != bslot_r) && marks_r[bslot_nxt]);
    end
    if (cmd.ack_load) begin
      out_kind_r <= srr_pkg::KIND_ACK;
      out_ack_r  <= seq_r;
      out_word_r <= '0;
      out_last_r <= st.ack_last;
    end else if (cmd.deliv_load) begin
      out_kind_r <= srr_pkg::KIND_DATA;
      out_ack_r  <= '0;
      out_word_r <= ram_rd_data;
      out_last_r <= run_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_ack_number     = out_ack_r;
  assign out_delivered_word = out_word_r;
  assign out_last_result    = out_last_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ack_load || cmd.deliv_load) |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");
  a_drain_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |-> marks_r[bslot_r])
    else $error("drain step on an unmarked slot");
  a_drain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |-> (count_r < w_eff))
    else $error("delivery run longer than the window");
  a_base_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |=> (base_r == $past(base_r) + SEQ_W'(1)))
    else $error("window base did not advance on delivery");
`endif

endmodule

>>> sv/selective_repeat_receiver_reorder_core.sv
// selective_repeat_receiver_reorder_core: top level of the selective-repeat receiver
// depends on srr_pkg, srr_ctrl, srr_dpath and srr_ram
//
// usage
//   in_*  : one packet per beat (valid/stall), seq number, payload word, checksum flag
//   out_* : result beats (valid/stall); an ack (kind 0) first, then in-order deliveries
//           (kind 1); out_last_result marks the final beat caused by one packet
//   cfg_* : window size write (valid/ready), taken only between packets
// sequence
//   an accepted packet passes intake and range check, then its ack is loaded; each
//   delivered word then takes a drain step (mark check and store read), then an output load
//   a dropped packet frees the input after its range check, a duplicate after its ack
//   a window write runs a remainder pass over the 32 bits of base (one bit of base per cycle)
//   to find the base slot; the input is held off during that pass
// reset
//   synchronous, active low: base 0, all marks clear, window 8, output empty
// stalls
//   one output register sits between the sequencer and the result channel;
//   while out_stall holds a pending result, the sequencer waits on its next result and the
//   input stays stalled until the packet's last beat has been loaded
module selective_repeat_receiver_reorder_core #(
  parameter int MAX_WINDOW   = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // packet input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srr_pkg::SEQ_W-1:0]     in_seq_number,
  input  logic [PAYLOAD_BITS-1:0]       in_data_word,
  input  logic                          in_checksum_ok,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [srr_pkg::SEQ_W-1:0]     out_ack_number,
  output logic [PAYLOAD_BITS-1:0]       out_delivered_word,
  output logic                          out_last_result,
  // window size write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srr_pkg::WIN_W-1:0]     cfg_window_size
);

  srr_pkg::cmd_t    cmd;
  srr_pkg::status_t st;

  // sequencer: packet intake, range check, ack, drain loop, window recompute
  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_valid(cfg_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall),
    .cfg_ready(cfg_ready)
  );

  // window state, reorder store and result register
  srr_dpath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_seq_number     (in_seq_number),
    .in_data_word      (in_data_word),
    .in_checksum_ok    (in_checksum_ok),
    .cfg_window_size   (cfg_window_size),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_ack_number    (out_ack_number),
    .out_delivered_word(out_delivered_word),
    .out_last_result   (out_last_result)
  );

`ifndef SYNTHESIS
  a_no_item_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check || cmd.drain_step || cmd.mod_step) |-> in_stall)
    else $error("input open while a packet or window pass is in progress");
  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (in_stall && !cfg_ready))
    else $error("window pass did not hold off the channels");
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.deliv_load && st.run_last) |=> !cmd.drain_step)
    else $error("drain continued past the last delivery");
`endif

endmodule
